// ===== design/scp_pkg.sv =====
// Shared types and constants for the sphere closest point block.
`default_nettype none
package scp_pkg;

    localparam int DIMS       = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [2:0] REG_CENTER_X  = 3'd0;
    localparam logic [2:0] REG_CENTER_Y  = 3'd1;
    localparam logic [2:0] REG_CENTER_Z  = 3'd2;
    localparam logic [2:0] REG_RADIUS    = 3'd3;
    localparam logic [2:0] REG_TOLERANCE = 3'd4;

    typedef struct packed {
        logic [2:0][31:0] center;
        logic [30:0]      radius;
        logic [30:0]      tolerance;
    } scp_cfg_t;

    // classified query handed from front to back
    typedef struct packed {
        logic [2:0][31:0] pt;
        logic [2:0]       neg;
        logic [2:0][63:0] prod;
        logic [65:0]      ssq;
        logic             in_ball;
        logic             cont;
    } scp_item_t;

endpackage
`default_nettype wire

// ===== design/scp_front.sv =====
// Front pipeline: differences, squares, sum of squares and classification.
`default_nettype none
module scp_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire scp_pkg::scp_cfg_t cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [2:0][31:0]  pt,
    input  wire logic              full,
    output logic                   push,
    output scp_pkg::scp_item_t     push_item
);
    import scp_pkg::*;

    logic             en;
    logic             a_v_reg, b_v_reg, c_v_reg, d_v_reg;
    logic [2:0][31:0] a_pt_reg, b_pt_reg, c_pt_reg;
    logic [2:0]       a_neg_reg, b_neg_reg, c_neg_reg;
    logic [2:0][32:0] a_mag_reg;
    logic [31:0]      a_lim_reg;
    logic [2:0][64:0] b_sq_reg;
    logic [2:0][63:0] b_prod_reg, c_prod_reg;
    logic [61:0]      b_r2_reg, c_r2_reg;
    logic [63:0]      b_lim2_reg, c_lim2_reg;
    logic [65:0]      c_ssq_reg;
    scp_item_t        d_item_reg;

    logic [2:0][32:0] a_mag_next;
    logic [2:0]       a_neg_next;
    logic [32:0]      diff;

    assign en        = !d_v_reg || !full;
    assign in_ready  = en;
    assign push      = d_v_reg && !full;
    assign push_item = d_item_reg;

    always_comb
    begin
        diff = '0;
        for (int i = 0; i < 3; i++)
        begin
            a_mag_next[i] = '0;
            a_neg_next[i] = 1'b0;
            if (i < DIMS)
            begin
                diff = {pt[i][31], pt[i]} - {cfg.center[i][31], cfg.center[i]};
                a_neg_next[i] = diff[32];
                a_mag_next[i] = diff[32] ? (~diff + 33'd1) : diff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_pt_reg  <= pt;
            a_neg_reg <= a_neg_next;
            a_mag_reg <= a_mag_next;
            a_lim_reg <= {1'b0, cfg.radius} + {1'b0, cfg.tolerance};

            b_pt_reg  <= a_pt_reg;
            b_neg_reg <= a_neg_reg;
            for (int i = 0; i < 3; i++)
            begin
                b_sq_reg[i]   <= 65'(66'(a_mag_reg[i]) * 66'(a_mag_reg[i]));
                b_prod_reg[i] <= 64'(64'(a_mag_reg[i]) * 64'(cfg.radius));
            end
            b_r2_reg   <= 62'(cfg.radius) * 62'(cfg.radius);
            b_lim2_reg <= 64'(a_lim_reg) * 64'(a_lim_reg);

            c_pt_reg   <= b_pt_reg;
            c_neg_reg  <= b_neg_reg;
            c_prod_reg <= b_prod_reg;
            c_r2_reg   <= b_r2_reg;
            c_lim2_reg <= b_lim2_reg;
            c_ssq_reg  <= 66'(b_sq_reg[0]) + 66'(b_sq_reg[1]) + 66'(b_sq_reg[2]);

            d_item_reg.pt      <= c_pt_reg;
            d_item_reg.neg     <= c_neg_reg;
            d_item_reg.prod    <= c_prod_reg;
            d_item_reg.ssq     <= c_ssq_reg;
            d_item_reg.in_ball <= c_ssq_reg < 66'(c_r2_reg);
            d_item_reg.cont    <= c_ssq_reg <= 66'(c_lim2_reg);
        end
    end

endmodule
`default_nettype wire

// ===== design/scp_fifo.sv =====
// Short queue between front and back pipelines.
`default_nettype none
module scp_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire scp_pkg::scp_item_t push_item,
    output logic                    full,
    input  wire logic               pop,
    output logic                    nonempty,
    output scp_pkg::scp_item_t      pop_item
);
    import scp_pkg::*;

    scp_item_t          mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_reg, rd_reg;
    logic [FIFO_AW:0]   cnt_reg;

    assign full     = cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH);
    assign nonempty = cnt_reg != '0;
    assign pop_item = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_item;
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("fifo count over depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full fifo");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !nonempty))
        else $error("pop from empty fifo");
`endif

endmodule
`default_nettype wire

// ===== design/scp_back.sv =====
// Back pipeline: square root, per-axis division by the norm, saturation.
`default_nettype none
module scp_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire scp_pkg::scp_cfg_t  cfg,
    input  wire logic               nonempty,
    input  wire scp_pkg::scp_item_t pop_item,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [2:0][31:0]        proj,
    output logic [32:0]             sdist,
    output logic                    cont
);
    import scp_pkg::*;

    localparam int SQ_STAGES = 33;
    localparam int DV_STAGES = 32;

    typedef struct packed {
        logic [2:0][31:0] pt;
        logic [2:0]       neg;
        logic [2:0][63:0] num;
        logic [32:0]      n;
        logic             bypass;
        logic [32:0]      gap;
        logic             cont;
    } div_item_t;

    logic en;

    // square root pipeline, one result bit per stage
    logic [SQ_STAGES-1:0] sq_v_reg;
    scp_item_t            sq_item_reg [SQ_STAGES];
    logic [33:0]          sq_rem_reg  [SQ_STAGES];
    logic [32:0]          sq_root_reg [SQ_STAGES];
    logic [SQ_STAGES:0]   sq_v_w;
    scp_item_t            sq_item_w   [SQ_STAGES+1];
    logic [33:0]          sq_rem_w    [SQ_STAGES+1];
    logic [32:0]          sq_root_w   [SQ_STAGES+1];
    logic [33:0]          sq_rem_next [SQ_STAGES];
    logic [32:0]          sq_root_next[SQ_STAGES];

    logic      md_v_reg;
    div_item_t md_item_reg;

    // restoring division, one quotient bit per stage for each axis
    logic [DV_STAGES-1:0] dv_v_reg;
    div_item_t            dv_item_reg [DV_STAGES];
    logic [2:0][32:0]     dv_rem_reg  [DV_STAGES];
    logic [2:0][31:0]     dv_q_reg    [DV_STAGES];
    logic [DV_STAGES:0]   dv_v_w;
    div_item_t            dv_item_w   [DV_STAGES+1];
    logic [2:0][32:0]     dv_rem_w    [DV_STAGES+1];
    logic [2:0][31:0]     dv_q_w      [DV_STAGES+1];
    logic [2:0][32:0]     dv_rem_next [DV_STAGES];
    logic [2:0][31:0]     dv_q_next   [DV_STAGES];

    logic             out_v_reg;
    logic [2:0][31:0] proj_reg;
    logic [32:0]      dist_reg;
    logic             cont_reg;
    logic [2:0][31:0] proj_next;

    logic [35:0] acc;
    logic [35:0] trial;
    logic [33:0] dacc;
    logic [33:0] mag;
    logic [33:0] off;
    logic [33:0] sum;
    logic [32:0] n_last;
    div_item_t   fin;

    assign en        = !out_v_reg || out_ready;
    assign pop       = en && nonempty;
    assign out_valid = out_v_reg;
    assign proj      = proj_reg;
    assign sdist     = dist_reg;
    assign cont      = cont_reg;

    assign sq_v_w[0]    = nonempty;
    assign sq_item_w[0] = pop_item;
    assign sq_rem_w[0]  = '0;
    assign sq_root_w[0] = '0;

    assign dv_v_w[0]    = md_v_reg;
    assign dv_item_w[0] = md_item_reg;
    assign dv_q_w[0]    = '0;

    for (genvar j = 0; j < SQ_STAGES; j++)
    begin : g_sq_link
        assign sq_v_w[j+1]    = sq_v_reg[j];
        assign sq_item_w[j+1] = sq_item_reg[j];
        assign sq_rem_w[j+1]  = sq_rem_reg[j];
        assign sq_root_w[j+1] = sq_root_reg[j];
    end

    for (genvar m = 0; m < DV_STAGES; m++)
    begin : g_dv_link
        assign dv_v_w[m+1]    = dv_v_reg[m];
        assign dv_item_w[m+1] = dv_item_reg[m];
        assign dv_rem_w[m+1]  = dv_rem_reg[m];
        assign dv_q_w[m+1]    = dv_q_reg[m];
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_dv_init
        assign dv_rem_w[0][i] = {1'b0, md_item_reg.num[i][63:32]};
    end

    always_comb
    begin
        acc   = '0;
        trial = '0;
        for (int j = 0; j < SQ_STAGES; j++)
        begin
            acc   = {sq_rem_w[j], sq_item_w[j].ssq[2*(SQ_STAGES-1-j) +: 2]};
            trial = {1'b0, sq_root_w[j], 2'b01};
            if (acc >= trial)
            begin
                sq_rem_next[j]  = 34'(acc - trial);
                sq_root_next[j] = {sq_root_w[j][31:0], 1'b1};
            end
            else
            begin
                sq_rem_next[j]  = acc[33:0];
                sq_root_next[j] = {sq_root_w[j][31:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        dacc = '0;
        for (int m = 0; m < DV_STAGES; m++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dacc = {dv_rem_w[m][i], dv_item_w[m].num[i][DV_STAGES-1-m]};
                if (dacc >= {1'b0, dv_item_w[m].n})
                begin
                    dv_rem_next[m][i] = 33'(dacc - {1'b0, dv_item_w[m].n});
                    dv_q_next[m][i]   = {dv_q_w[m][i][30:0], 1'b1};
                end
                else
                begin
                    dv_rem_next[m][i] = dacc[32:0];
                    dv_q_next[m][i]   = {dv_q_w[m][i][30:0], 1'b0};
                end
            end
        end
    end

    assign fin    = dv_item_reg[DV_STAGES-1];
    assign n_last = sq_root_reg[SQ_STAGES-1];

    always_comb
    begin
        mag = '0;
        off = '0;
        sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag = {2'b00, dv_q_reg[DV_STAGES-1][i]};
            off = fin.neg[i] ? (~mag + 34'd1) : mag;
            sum = {{2{cfg.center[i][31]}}, cfg.center[i]} + off;
            if (fin.bypass || i >= DIMS)
                proj_next[i] = fin.pt[i];
            else if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111)
                proj_next[i] = sum[31:0];
            else if (sum[33])
                proj_next[i] = 32'h8000_0000;
            else
                proj_next[i] = 32'h7FFF_FFFF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg  <= '0;
            md_v_reg  <= 1'b0;
            dv_v_reg  <= '0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_v_reg  <= sq_v_w[SQ_STAGES-1:0];
            md_v_reg  <= sq_v_reg[SQ_STAGES-1];
            dv_v_reg  <= dv_v_w[DV_STAGES-1:0];
            out_v_reg <= dv_v_reg[DV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < SQ_STAGES; j++)
            begin
                sq_item_reg[j] <= sq_item_w[j];
                sq_rem_reg[j]  <= sq_rem_next[j];
                sq_root_reg[j] <= sq_root_next[j];
            end

            md_item_reg.pt     <= sq_item_reg[SQ_STAGES-1].pt;
            md_item_reg.neg    <= sq_item_reg[SQ_STAGES-1].neg;
            md_item_reg.n      <= n_last;
            md_item_reg.cont   <= sq_item_reg[SQ_STAGES-1].cont;
            md_item_reg.bypass <= sq_item_reg[SQ_STAGES-1].in_ball || n_last == '0;
            md_item_reg.gap    <= n_last - {2'b00, cfg.radius};
            for (int i = 0; i < 3; i++)
                md_item_reg.num[i] <= sq_item_reg[SQ_STAGES-1].prod[i]
                                      + {32'd0, n_last[32:1]};

            for (int m = 0; m < DV_STAGES; m++)
            begin
                dv_item_reg[m] <= dv_item_w[m];
                dv_rem_reg[m]  <= dv_rem_next[m];
                dv_q_reg[m]    <= dv_q_next[m];
            end

            proj_reg <= proj_next;
            dist_reg <= fin.bypass ? 33'd0 : fin.gap;
            cont_reg <= fin.cont;
        end
    end

`ifndef SYNTHESIS
    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> sq_v_reg[0])
        else $error("popped item lost at sqrt entry");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(proj_reg) && $stable(dist_reg))
        else $error("result changed during stall");
    a_pop_only_moving: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> en)
        else $error("pop while back pipeline stalled");
`endif

endmodule
`default_nettype wire

// ===== design/sphere_closest_point.sv =====
// Top level of the sphere closest point block: config registers, front, queue, back.
//
//  channel   signals                                   direction  transfer when
//  config    psel penable pwrite paddr pwdata prdata   in/out     psel & penable & pready
//  in        in_valid in_ready point_x/y/z             in         in_valid & in_ready
//  out       out_valid out_ready proj_x/y/z, distance  out        out_valid & out_ready
//
// One item per cycle sustained while out_ready stays high; path: 4 front stages, queue,
// 33 square root stages (one root bit each), 1 rounding stage, 32 division stages
// (one quotient bit each) and the output register.
// Reset clears valid bits and queue pointers; config registers reset to zero.
// An output stall freezes the back pipeline; the queue then fills and stalls the front.
`default_nettype none
module sphere_closest_point (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] point_x,
    input  wire logic [31:0] point_y,
    input  wire logic [31:0] point_z,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      proj_x,
    output logic [31:0]      proj_y,
    output logic [31:0]      proj_z,
    output logic [32:0]      surface_distance,
    output logic             contained
);
    import scp_pkg::*;

    scp_cfg_t         cfg_reg;
    logic [2:0]       idx;
    logic             wr;
    logic             push, full, pop, nonempty;
    scp_item_t        push_item, pop_item;
    logic [2:0][31:0] pt, proj;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite && pready;
    assign pt     = {point_z, point_y, point_x};
    assign proj_x = proj[0];
    assign proj_y = proj[1];
    assign proj_z = proj[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (wr)
        begin
            unique case (idx)
                REG_CENTER_X:  cfg_reg.center[0] <= pwdata;
                REG_CENTER_Y:  cfg_reg.center[1] <= pwdata;
                REG_CENTER_Z:  cfg_reg.center[2] <= pwdata;
                REG_RADIUS:    cfg_reg.radius    <= pwdata[30:0];
                REG_TOLERANCE: cfg_reg.tolerance <= pwdata[30:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_CENTER_X:  prdata = cfg_reg.center[0];
            REG_CENTER_Y:  prdata = cfg_reg.center[1];
            REG_CENTER_Z:  prdata = cfg_reg.center[2];
            REG_RADIUS:    prdata = {1'b0, cfg_reg.radius};
            REG_TOLERANCE: prdata = {1'b0, cfg_reg.tolerance};
            default:       prdata = '0;
        endcase
    end

    scp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pt        (pt),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    scp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .nonempty  (nonempty),
        .pop_item  (pop_item)
    );

    scp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .nonempty  (nonempty),
        .pop_item  (pop_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .proj      (proj),
        .sdist     (surface_distance),
        .cont      (contained)
    );

endmodule
`default_nettype wire

// ===== tb/tb_sphere_closest_point.sv =====
// Testbench for sphere_closest_point: APB setup, random point stream, scoreboard check.
`default_nettype none
module tb_sphere_closest_point;
    import scp_pkg::*;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [32:0] gap;
        logic        cont;
    } sphere_hit_t;

    class projection_board;
        logic signed [31:0] ctr [3];
        logic [30:0]        rad;
        logic [30:0]        tol;
        sphere_hit_t        pending [$];

        function new();
            ctr[0] = 0;
            ctr[1] = 0;
            ctr[2] = 0;
            rad = 0;
            tol = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_CENTER_X:  ctr[0] = val;
                REG_CENTER_Y:  ctr[1] = val;
                REG_CENTER_Z:  ctr[2] = val;
                REG_RADIUS:    rad = val[30:0];
                REG_TOLERANCE: tol = val[30:0];
                default: ;
            endcase
        endfunction

        function logic [37:0] floor_root(logic [67:0] s);
            logic [37:0] r;
            logic [79:0] t;
            r = 0;
            for (int b = 36; b >= 0; b--)
            begin
                t = r | (38'd1 << b);
                if (t * t <= {12'd0, s})
                    r = t[37:0];
            end
            return r;
        endfunction

        // note an accepted point and queue the projection it should produce
        function void note_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
            logic signed [31:0] p [3];
            logic signed [33:0] d [3];
            logic [32:0]        mag [3];
            logic [67:0]        s;
            logic [67:0]        mm;
            logic [37:0]        n;
            logic [79:0]        m;
            logic signed [81:0] v;
            logic [32:0]        lim;
            logic [79:0]        span;
            sphere_hit_t        e;
            p[0] = px;
            p[1] = py;
            p[2] = pz;
            s = 0;
            for (int i = 0; i < 3; i++)
            begin
                d[i] = 34'(p[i]) - 34'(ctr[i]);
                mag[i] = d[i] < 0 ? 33'(-d[i]) : 33'(d[i]);
                mm = mag[i];
                if (i < DIMS)
                    s = s + mm * mm;
            end
            n = floor_root(s);
            e.x = px;
            e.y = py;
            e.z = pz;
            e.gap = 0;
            mm = rad;
            if (!(s < mm * mm || n == 0))
            begin
                for (int i = 0; i < DIMS; i++)
                begin
                    m = (80'(mag[i]) * 80'(rad) + 80'(n >> 1)) / 80'(n);
                    v = 82'(ctr[i]) + (d[i] < 0 ? -$signed({2'b00, m}) : $signed({2'b00, m}));
                    if (v > 82'sh7FFFFFFF)
                        v = 82'sh7FFFFFFF;
                    else if (v < -82'sh80000000)
                        v = -82'sh80000000;
                    if (i == 0) e.x = v[31:0];
                    if (i == 1) e.y = v[31:0];
                    if (i == 2) e.z = v[31:0];
                end
                span = 80'(n) - 80'(rad);
                e.gap = span > 80'h1FFFFFFFF ? 33'h1FFFFFFFF : span[32:0];
            end
            lim = 33'(rad) + 33'(tol);
            span = 80'(lim) * 80'(lim);
            e.cont = {12'd0, s} <= span;
            pending.push_back(e);
        endfunction

        // empty string when the result matches the oldest expectation
        function string check_result(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                     logic [32:0] sdist, logic cont);
            sphere_hit_t e;
            string msg;
            if (pending.size() == 0)
                return "result with nothing expected";
            e = pending.pop_front();
            msg = "";
            if (x !== e.x) msg = {msg, $sformatf(" proj_x %h/%h", x, e.x)};
            if (y !== e.y) msg = {msg, $sformatf(" proj_y %h/%h", y, e.y)};
            if (z !== e.z) msg = {msg, $sformatf(" proj_z %h/%h", z, e.z)};
            if (sdist !== e.gap) msg = {msg, $sformatf(" dist %h/%h", sdist, e.gap)};
            if (cont !== e.cont) msg = {msg, $sformatf(" contained %b/%b", cont, e.cont)};
            return msg;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] proj_x;
    logic [31:0] proj_y;
    logic [31:0] proj_z;
    logic [32:0] surface_distance;
    logic        contained;

    projection_board board;
    int          errors;
    int          cycles;
    bit          calm;

    sphere_closest_point dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .proj_x(proj_x), .proj_y(proj_y), .proj_z(proj_z),
        .surface_distance(surface_distance), .contained(contained)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 300000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report(string what);
        $display("MISMATCH at cycle %0d:%s", cycles, what);
        errors++;
    endtask

    // receiving side: ready toggles at the falling edge, transfers checked at the rising edge
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = calm || ($urandom_range(0, 99) >= 34);
        end
    end

    always @(posedge clk)
    begin
        string msg;
        if (rst_n && out_valid && out_ready)
        begin
            msg = board.check_result(proj_x, proj_y, proj_z, surface_distance, contained);
            if (msg != "")
                report(msg);
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        board.write_reg(idx, val);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [31:0] r, logic [31:0] t);
        in_valid = 1'b0;
        drain();
        reg_write(REG_CENTER_X, cx);
        reg_write(REG_CENTER_Y, cy);
        reg_write(REG_CENTER_Z, cz);
        reg_write(REG_RADIUS, r);
        reg_write(REG_TOLERANCE, t);
    endtask

    // one transfer on the input channel; called at a falling edge
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while (!calm && $urandom_range(0, 99) < 34)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        point_x = x;
        point_y = y;
        point_z = z;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_point(x, y, z);
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_coord(logic [31:0] c, logic [30:0] r);
        case ($urandom_range(0, 9))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return c;
            3: return c + {1'b0, r};
            4: return c - {1'b0, r};
            5, 6: return c + 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
            7: return c + ({1'b0, r} >> $urandom_range(0, 8)) - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_points(int count);
        for (int k = 0; k < count; k++)
            send_point(pick_coord(board.ctr[0], board.rad),
                       pick_coord(board.ctr[1], board.rad),
                       pick_coord(board.ctr[2], board.rad));
    endtask

    initial
    begin
        board = new();
        errors = 0;
        cycles = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        point_x = '0;
        point_y = '0;
        point_z = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero sphere at origin: zero norm with zero radius, extremes
        send_point(0, 0, 0);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_point(32'h80000000, 32'h80000000, 32'h80000000);
        send_point(32'h00010000, 0, 0);
        set_sphere(0, 0, 0, 32'h00010000, 32'h00004000);
        send_point(0, 0, 0);
        send_point(32'h00008000, 0, 0);
        send_point(32'h00010000, 0, 0);
        send_point(32'h00012000, 0, 0);
        send_point(32'h00030000, 32'hFFFD0000, 32'h00040000);
        send_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        send_point(32'hFFFFFFFF, 32'h00000001, 0);
        // upper extremes of the registers; bit 31 of radius is dropped
        set_sphere(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF);
        send_point(32'h80000000, 32'h80000000, 32'h80000000);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_point(0, 0, 0);
        send_point(32'h80000000, 32'h7FFFFFFF, 0);
        set_sphere(32'h80000000, 32'h80000000, 32'h80000000, 32'h00000001, 0);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_point(32'h80000000, 32'h80000000, 32'h80000000);
        send_point(32'h80000001, 32'h80000000, 32'h80000000);
        send_point(0, 32'h80000000, 32'h80000000);

        set_sphere($urandom, $urandom, $urandom, 32'h00050000, 32'h00008000);
        random_points(250);
        // let the pipeline empty completely before continuing
        in_valid = 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        random_points(100);
        calm = 1'b1;
        random_points(250);
        calm = 1'b0;
        set_sphere(0, 0, 0, 32'h7FFFFFFF, 0);
        random_points(200);
        set_sphere($urandom, $urandom, $urandom, 0, $urandom);
        random_points(200);
        for (int ph = 0; ph < 3; ph++)
        begin
            set_sphere($urandom, $urandom, $urandom, $urandom_range(0, 32'h00200000), $urandom);
            random_points(180);
        end

        in_valid = 1'b0;
        drain();
        if (board.pending.size() != 0)
            report(" expectations left over");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
